FILE: design/pca_pkg.sv
// Shared types, widths and constants of the conditional anti-windup PID block.
package pca_pkg;

   // Field and register widths
   localparam int GAIN_W     = 24;
   localparam int VAL_W      = 32;
   localparam int DT_W       = 24;
   localparam int ERR_W      = VAL_W + 1;
   localparam int CSR_IDX_W  = 3;

   // Shared multiplier: 24-bit unsigned times 40-bit signed in two 20-bit halves
   localparam int MUL_X_W    = 40;
   localparam int MUL_LO_W   = 20;
   localparam int MUL_HI_W   = MUL_X_W - MUL_LO_W;
   localparam int PROD_W     = (GAIN_W + 1) + (MUL_HI_W + 1);
   localparam int SUM_W      = 64;

   // Derivative divider
   localparam int DER_MAG_W  = 38;
   localparam int DER_W      = DER_MAG_W + 1;
   localparam int DIV_STEPS  = DER_MAG_W / 2;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
   localparam int REM_W      = DT_W;
   localparam logic [DER_MAG_W-1:0] DER_LIMIT = '1;

   // Term widths after the fixed-point shifts
   localparam int P_W        = 42;
   localparam int I_W        = 40;
   localparam int INC_W      = 33;
   localparam int D_W        = 47;
   localparam int POT_W      = P_W + 1;
   localparam int ACC_SUM_W  = INC_W + 1;
   localparam int DRV_SUM_W  = 49;

   localparam logic signed [VAL_W-1:0] NEAR_ZERO_POS = 32'sd655;
   localparam logic signed [VAL_W-1:0] NEAR_ZERO_NEG = -32'sd655;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_GAIN_P      = 3'd0,
      REG_GAIN_I      = 3'd1,
      REG_GAIN_D      = 3'd2,
      REG_DRIVE_UPPER = 3'd3,
      REG_DRIVE_LOWER = 3'd4,
      REG_ACCUM_UPPER = 3'd5,
      REG_ACCUM_LOWER = 3'd6
   } csr_reg_type;

   typedef struct packed {
      logic        [GAIN_W-1:0] gain_proportional;
      logic        [GAIN_W-1:0] gain_integral;
      logic        [GAIN_W-1:0] gain_derivative;
      logic signed [VAL_W-1:0]  drive_upper;
      logic signed [VAL_W-1:0]  drive_lower;
      logic signed [VAL_W-1:0]  accum_upper;
      logic signed [VAL_W-1:0]  accum_lower;
   } cfg_type;

   typedef struct packed {
      logic                      start;
      logic        [GAIN_W-1:0]  a;
      logic signed [MUL_X_W-1:0] x;
   } mul_req_type;

   typedef struct packed {
      logic                    done;
      logic signed [SUM_W-1:0] product;
   } mul_rsp_type;

   typedef struct packed {
      logic                    start;
      logic signed [ERR_W-1:0] diff;
      logic        [DT_W-1:0]  dt;
   } div_req_type;

   typedef struct packed {
      logic                    valid;
      logic signed [DER_W-1:0] der;
   } div_rsp_type;

   typedef enum logic [1:0] {
      MUL_IDLE,
      MUL_LOW,
      MUL_ADD
   } mul_phase_type;

   typedef enum logic [3:0] {
      SEQ_IDLE,
      SEQ_P_ISSUE,
      SEQ_P_WAIT,
      SEQ_I0_ISSUE,
      SEQ_I0_WAIT,
      SEQ_INC_ISSUE,
      SEQ_INC_WAIT,
      SEQ_I_ISSUE,
      SEQ_I_WAIT,
      SEQ_D_ISSUE,
      SEQ_D_WAIT,
      SEQ_PUSH
   } seq_state_type;

endpackage

FILE: design/pca_mul.sv
// Shared multiplier: 24-bit unsigned by 40-bit signed.
module pca_mul (
   input  logic               clock,
   input  logic               reset,
   input  pca_pkg::mul_req_type mul_req,
   output pca_pkg::mul_rsp_type mul_rsp
);
   import pca_pkg::*;

   mul_phase_type             phase_ff, phase_in;
   logic        [GAIN_W-1:0]  a_ff;
   logic        [MUL_LO_W-1:0] lo_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [SUM_W-1:0]   sum_ff;
   logic                      done_ff;

   logic        [GAIN_W-1:0]  op_a;
   logic signed [GAIN_W:0]    op_a_s;
   logic signed [MUL_LO_W:0]  op_x;
   logic signed [PROD_W-1:0]  product_in;

   // High half straight from the request, low half from the latched operand
   always_comb begin
      if (phase_ff == MUL_IDLE) begin
         op_a = mul_req.a;
         op_x = signed'({mul_req.x[MUL_X_W-1], mul_req.x[MUL_X_W-1:MUL_LO_W]});
      end else begin
         op_a = a_ff;
         op_x = signed'({1'b0, lo_ff});
      end
      op_a_s     = signed'({1'b0, op_a});
      product_in = op_a_s * op_x;
   end

   always_comb begin
      case (phase_ff)
         MUL_IDLE: phase_in = mul_req.start ? MUL_LOW : MUL_IDLE;
         MUL_LOW:  phase_in = MUL_ADD;
         MUL_ADD:  phase_in = MUL_IDLE;
         default:  phase_in = MUL_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= MUL_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= (phase_ff == MUL_ADD);
      end
   end

   always_ff @(posedge clock) begin
      case (phase_ff)
         MUL_IDLE: begin
            if (mul_req.start) begin
               a_ff    <= mul_req.a;
               lo_ff   <= mul_req.x[MUL_LO_W-1:0];
               prod_ff <= product_in;
            end
         end
         MUL_LOW: begin
            sum_ff  <= SUM_W'(prod_ff);
            prod_ff <= product_in;
         end
         MUL_ADD: begin
            sum_ff <= (sum_ff <<< MUL_LO_W) + SUM_W'(prod_ff);
         end
         default: begin
            sum_ff <= sum_ff;
         end
      endcase
   end

   assign mul_rsp.done    = done_ff;
   assign mul_rsp.product = sum_ff;

endmodule

FILE: design/pca_div.sv
// Radix-4 restoring divider for the derivative rate, with early saturation.
module pca_div (
   input  logic               clock,
   input  logic               reset,
   input  pca_pkg::div_req_type div_req,
   output pca_pkg::div_rsp_type div_rsp
);
   import pca_pkg::*;

   logic                  busy_ff;
   logic                  valid_ff;
   logic                  sat_ff;
   logic                  neg_ff;
   logic [DIV_CNT_W-1:0]  cnt_ff;
   logic [REM_W-1:0]      rem_ff;
   logic [DER_MAG_W-1:0]  q_ff;
   logic [DT_W-1:0]       dt_ff;

   logic [ERR_W-1:0]      mag;
   logic                  sat;
   logic [REM_W:0]        r1;
   logic [REM_W:0]        r1s;
   logic [REM_W:0]        r2;
   logic [REM_W:0]        r2s;
   logic                  b1;
   logic                  b2;
   logic [DER_MAG_W-1:0]  mag_q;
   logic [DER_W-1:0]      der_mag;

   // Quotient reaches 2^38 exactly when |diff| >= dt * 2^14
   always_comb begin
      mag = div_req.diff[ERR_W-1] ? ERR_W'(-div_req.diff) : ERR_W'(div_req.diff);
      sat = {{(DER_MAG_W-ERR_W){1'b0}}, mag} >= {div_req.dt, 14'b0};
   end

   // Two quotient bits per cycle
   always_comb begin
      r1  = {rem_ff, q_ff[DER_MAG_W-1]};
      b1  = r1 >= {1'b0, dt_ff};
      r1s = b1 ? r1 - {1'b0, dt_ff} : r1;
      r2  = {r1s[REM_W-1:0], q_ff[DER_MAG_W-2]};
      b2  = r2 >= {1'b0, dt_ff};
      r2s = b2 ? r2 - {1'b0, dt_ff} : r2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else if (div_req.start) begin
         busy_ff  <= !sat;
         valid_ff <= sat;
      end else if (busy_ff && cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         sat_ff <= sat;
         neg_ff <= div_req.diff[ERR_W-1];
         dt_ff  <= div_req.dt;
         cnt_ff <= '0;
         rem_ff <= {{(REM_W-(ERR_W-14)){1'b0}}, mag[ERR_W-1:14]};
         q_ff   <= {mag[13:0], {(DER_MAG_W-14){1'b0}}};
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         rem_ff <= r2s[REM_W-1:0];
         q_ff   <= {q_ff[DER_MAG_W-3:0], b1, b2};
      end
   end

   always_comb begin
      mag_q   = sat_ff ? DER_LIMIT : q_ff;
      der_mag = {1'b0, mag_q};
      div_rsp.valid = valid_ff;
      div_rsp.der   = neg_ff ? signed'(-der_mag) : signed'(der_mag);
   end

endmodule

FILE: design/pca_csr.sv
// Configuration register file: gains and clamp limits.
module pca_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [pca_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pca_pkg::VAL_W-1:0]       csr_write_data,
   output pca_pkg::cfg_type                cfg
);
   import pca_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_proportional <= 24'd196608;
         cfg_ff.gain_integral     <= 24'd65536;
         cfg_ff.gain_derivative   <= 24'd22938;
         cfg_ff.drive_upper       <= 32'sd655360;
         cfg_ff.drive_lower       <= -32'sd655360;
         cfg_ff.accum_upper       <= 32'sd655360;
         cfg_ff.accum_lower       <= -32'sd655360;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_GAIN_P:      cfg_ff.gain_proportional <= csr_write_data[GAIN_W-1:0];
            REG_GAIN_I:      cfg_ff.gain_integral     <= csr_write_data[GAIN_W-1:0];
            REG_GAIN_D:      cfg_ff.gain_derivative   <= csr_write_data[GAIN_W-1:0];
            REG_DRIVE_UPPER: cfg_ff.drive_upper       <= signed'(csr_write_data);
            REG_DRIVE_LOWER: cfg_ff.drive_lower       <= signed'(csr_write_data);
            REG_ACCUM_UPPER: cfg_ff.accum_upper       <= signed'(csr_write_data);
            REG_ACCUM_LOWER: cfg_ff.accum_lower       <= signed'(csr_write_data);
            default:         cfg_ff <= cfg_ff;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: design/pca_core.sv
// Sequencer and term datapath around the shared multiplier and the divider.
module pca_core (
   input  logic                              clock,
   input  logic                              reset,
   input  pca_pkg::cfg_type                  cfg,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [pca_pkg::VAL_W-1:0]  req_target,
   input  logic signed [pca_pkg::VAL_W-1:0]  req_measurement,
   input  logic        [pca_pkg::DT_W-1:0]   req_time_step,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [pca_pkg::VAL_W-1:0]  rsp_drive
);
   import pca_pkg::*;

   seq_state_type state_ff, state_in;

   logic signed [ERR_W-1:0]  err_ff;
   logic signed [VAL_W-1:0]  meas_ff;
   logic        [DT_W-1:0]   dt_ff;
   logic signed [VAL_W-1:0]  accum_ff;
   logic signed [VAL_W-1:0]  last_meas_ff;
   logic signed [P_W-1:0]    p_ff;
   logic signed [I_W-1:0]    i_ff;
   logic                     integrate_ff;
   logic signed [VAL_W-1:0]  drive_ff;
   logic                     rsp_valid_ff;
   logic signed [VAL_W-1:0]  rsp_drive_ff;

   mul_req_type mul_req;
   mul_rsp_type mul_rsp;
   div_req_type div_req;
   div_rsp_type div_rsp;

   logic                     accepted;
   logic                     near_zero;
   logic                     out_free;
   logic        [DT_W-1:0]   dt_fix;
   logic signed [P_W-1:0]    p_new;
   logic signed [I_W-1:0]    i_new;
   logic signed [INC_W-1:0]  inc_new;
   logic signed [D_W-1:0]    d_new;
   logic signed [POT_W-1:0]  pot;
   logic signed [POT_W-1:0]  pot_hi;
   logic signed [POT_W-1:0]  pot_lo;
   logic                     err_pos;
   logic                     err_neg;
   logic                     integrate;
   logic signed [ACC_SUM_W-1:0] acc_sum;
   logic signed [ACC_SUM_W-1:0] acc_top;
   logic signed [VAL_W-1:0]  acc_new;
   logic signed [DRV_SUM_W-1:0] drv_sum;
   logic signed [DRV_SUM_W-1:0] drv_top;
   logic signed [VAL_W-1:0]  drv_new;

   pca_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   pca_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Accept and launch the derivative division at once
   always_comb begin
      accepted  = req_valid && (state_ff == SEQ_IDLE);
      near_zero = (req_target <= NEAR_ZERO_POS) && (req_target >= NEAR_ZERO_NEG);
      dt_fix    = (req_time_step == '0) ? DT_W'(1) : req_time_step;
      out_free  = !rsp_valid_ff || rsp_ready;
      div_req.start = accepted;
      div_req.diff  = ERR_W'(req_measurement) - ERR_W'(last_meas_ff);
      div_req.dt    = dt_fix;
   end

   // Term arithmetic on the multiplier result
   always_comb begin
      p_new   = mul_rsp.product[P_W+15:16];
      i_new   = mul_rsp.product[I_W+15:16];
      inc_new = mul_rsp.product[INC_W+23:24];
      d_new   = mul_rsp.product[D_W+15:16];

      pot     = POT_W'(p_ff) + POT_W'(i_new);
      pot_hi  = POT_W'(cfg.drive_upper);
      pot_lo  = POT_W'(cfg.drive_lower);
      err_neg = err_ff[ERR_W-1];
      err_pos = !err_ff[ERR_W-1] && (err_ff != '0);
      integrate = ((pot < pot_hi) && (pot > pot_lo)) ||
                  (err_pos && (pot < pot_lo)) ||
                  (err_neg && (pot > pot_hi));

      // Upper clamp first, lower clamp wins
      acc_sum = ACC_SUM_W'(accum_ff) + ACC_SUM_W'(inc_new);
      acc_top = (acc_sum > ACC_SUM_W'(cfg.accum_upper)) ?
                ACC_SUM_W'(cfg.accum_upper) : acc_sum;
      acc_new = (acc_top < ACC_SUM_W'(cfg.accum_lower)) ?
                cfg.accum_lower : acc_top[VAL_W-1:0];

      drv_sum = DRV_SUM_W'(p_ff) + DRV_SUM_W'(i_ff) - DRV_SUM_W'(d_new);
      drv_top = (drv_sum > DRV_SUM_W'(cfg.drive_upper)) ?
                DRV_SUM_W'(cfg.drive_upper) : drv_sum;
      drv_new = (drv_top < DRV_SUM_W'(cfg.drive_lower)) ?
                cfg.drive_lower : drv_top[VAL_W-1:0];
   end

   // Next state
   always_comb begin
      case (state_ff)
         SEQ_IDLE:      state_in = req_valid ? SEQ_P_ISSUE : SEQ_IDLE;
         SEQ_P_ISSUE:   state_in = SEQ_P_WAIT;
         SEQ_P_WAIT:    state_in = mul_rsp.done ? SEQ_I0_ISSUE : SEQ_P_WAIT;
         SEQ_I0_ISSUE:  state_in = SEQ_I0_WAIT;
         SEQ_I0_WAIT:   state_in = mul_rsp.done ? SEQ_INC_ISSUE : SEQ_I0_WAIT;
         SEQ_INC_ISSUE: state_in = SEQ_INC_WAIT;
         SEQ_INC_WAIT:  state_in = mul_rsp.done ? SEQ_I_ISSUE : SEQ_INC_WAIT;
         SEQ_I_ISSUE:   state_in = SEQ_I_WAIT;
         SEQ_I_WAIT:    state_in = mul_rsp.done ? SEQ_D_ISSUE : SEQ_I_WAIT;
         SEQ_D_ISSUE:   state_in = div_rsp.valid ? SEQ_D_WAIT : SEQ_D_ISSUE;
         SEQ_D_WAIT:    state_in = mul_rsp.done ? SEQ_PUSH : SEQ_D_WAIT;
         SEQ_PUSH:      state_in = out_free ? SEQ_IDLE : SEQ_PUSH;
         default:       state_in = SEQ_IDLE;
      endcase
   end

   // Multiplier operand selection
   always_comb begin
      mul_req.start = 1'b0;
      mul_req.a     = cfg.gain_proportional;
      mul_req.x     = MUL_X_W'(err_ff);
      case (state_ff)
         SEQ_P_ISSUE: begin
            mul_req.start = 1'b1;
         end
         SEQ_I0_ISSUE, SEQ_I_ISSUE: begin
            mul_req.start = 1'b1;
            mul_req.a     = cfg.gain_integral;
            mul_req.x     = MUL_X_W'(accum_ff);
         end
         SEQ_INC_ISSUE: begin
            mul_req.start = 1'b1;
            mul_req.a     = dt_ff;
         end
         SEQ_D_ISSUE: begin
            mul_req.start = div_rsp.valid;
            mul_req.a     = cfg.gain_derivative;
            mul_req.x     = MUL_X_W'(div_rsp.der);
         end
         default: begin
            mul_req.start = 1'b0;
         end
      endcase
   end

   // Control and controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         rsp_valid_ff <= 1'b0;
         accum_ff     <= '0;
         last_meas_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (accepted && near_zero) begin
            accum_ff <= '0;
         end else if (state_ff == SEQ_INC_WAIT && mul_rsp.done && integrate_ff) begin
            accum_ff <= acc_new;
         end
         if (state_ff == SEQ_D_WAIT && mul_rsp.done) begin
            last_meas_ff <= meas_ff;
         end
         if (state_ff == SEQ_PUSH && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (accepted) begin
         err_ff  <= ERR_W'(req_target) - ERR_W'(req_measurement);
         meas_ff <= req_measurement;
         dt_ff   <= dt_fix;
      end
      if (state_ff == SEQ_P_WAIT && mul_rsp.done) begin
         p_ff <= p_new;
      end
      if (state_ff == SEQ_I0_WAIT && mul_rsp.done) begin
         integrate_ff <= integrate;
      end
      if (state_ff == SEQ_I_WAIT && mul_rsp.done) begin
         i_ff <= i_new;
      end
      if (state_ff == SEQ_D_WAIT && mul_rsp.done) begin
         drive_ff <= drv_new;
      end
      if (state_ff == SEQ_PUSH && out_free) begin
         rsp_drive_ff <= drive_ff;
      end
   end

   assign req_ready = (state_ff == SEQ_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = rsp_drive_ff;

endmodule

FILE: design/pid_conditional_antiwindup_top.sv
// Top level of the fixed-point PID controller with conditional-integration anti-windup.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+----------------------------------------
//   req     | in        | req_valid / req_ready  | req_target, req_measurement, req_time_step
//   rsp     | out       | rsp_valid / rsp_ready  | rsp_drive
//   csr     | in        | csr_write_enable       | csr_index, csr_write_data
//
// The radix-4 divider starts on acceptance, beside four products (P, I before integration,
// increment, I after); the D product follows the division, and the load of the result
// ends the item. A saturated rate skips the division. req_ready is high only while the
// sequencer is idle; a held result stalls only the load of the next one.
// Reset is synchronous and active high; it restores the register defaults and clears the state.
module pid_conditional_antiwindup_top (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [pca_pkg::VAL_W-1:0]  req_target,
   input  logic signed [pca_pkg::VAL_W-1:0]  req_measurement,
   input  logic        [pca_pkg::DT_W-1:0]   req_time_step,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [pca_pkg::VAL_W-1:0]  rsp_drive,

   input  logic                              csr_write_enable,
   input  logic [pca_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pca_pkg::VAL_W-1:0]         csr_write_data
);
   import pca_pkg::*;

   cfg_type cfg;

   // Gains and limits; the user writes them only while no item is in flight; not enforced
   pca_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // Sequencer, shared multiplier, divider and output register
   pca_core u_core (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_target      (req_target),
      .req_measurement (req_measurement),
      .req_time_step   (req_time_step),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_drive       (rsp_drive)
   );

endmodule

FILE: design/pca_checker.sv
// Port-level checks of the PID block, bound to the top level.
module pca_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [pca_pkg::VAL_W-1:0]  rsp_drive
);
   import pca_pkg::*;

   logic [1:0] inflight_ff, inflight_in;
   logic       req_fire;
   logic       rsp_fire;

   // Track items accepted but not yet delivered
   always_comb begin
      req_fire    = req_valid && req_ready;
      rsp_fire    = rsp_valid && rsp_ready;
      inflight_in = inflight_ff + {1'b0, req_fire} - {1'b0, rsp_fire};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("req_ready stayed high after an item was accepted");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_drive)))
      else $error("stalled result dropped or changed");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (inflight_ff != 2'd0))
      else $error("result shown with no item in flight");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      inflight_ff != 2'd3)
      else $error("more than two items in flight");

endmodule

bind pid_conditional_antiwindup_top pca_checker u_pca_checker (.*);
